// File: design/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CHK_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/iecs_pkg.sv
// Types and constants of the I2C EEPROM access sequencer.
package iecs_pkg;

	localparam int MAX_BURST_DEF = 256;
	localparam int QDEPTH        = 2;

	localparam logic [1:0] FUNC_BEGIN  = 2'd0;
	localparam logic [1:0] FUNC_SUPPLY = 2'd1;
	localparam logic [1:0] FUNC_STEP   = 2'd2;

	typedef enum logic [1:0] {
		K_NONE   = 2'd0,
		K_BEGIN  = 2'd1,
		K_SUPPLY = 2'd2,
		K_STEP   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_START   = 3'd1,
		ACT_RESTART = 3'd2,
		ACT_SEND    = 3'd3,
		ACT_RECV    = 3'd4,
		ACT_ACK     = 3'd5,
		ACT_NACK    = 3'd6,
		ACT_STOP    = 3'd7
	} act_t;

	typedef enum logic [2:0] {
		ST_OK   = 3'd0,
		ST_DEV  = 3'd1,
		ST_AHI  = 3'd2,
		ST_ALO  = 3'd3,
		ST_RSEL = 3'd4
	} st_t;

	typedef enum logic [11:0] {
		PH_IDLE    = 12'b0000_0000_0001,
		PH_START   = 12'b0000_0000_0010,
		PH_DEV     = 12'b0000_0000_0100,
		PH_AHI     = 12'b0000_0000_1000,
		PH_ALO     = 12'b0000_0001_0000,
		PH_WDATA   = 12'b0000_0010_0000,
		PH_SDATA   = 12'b0000_0100_0000,
		PH_RESTART = 12'b0000_1000_0000,
		PH_RSEL    = 12'b0001_0000_0000,
		PH_RECV    = 12'b0010_0000_0000,
		PH_ACKING  = 12'b0100_0000_0000,
		PH_STOP    = 12'b1000_0000_0000
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic        op_read;
		logic [7:0]  device_byte;
		logic [15:0] mem_address;
		logic [8:0]  burst_length;
		logic [7:0]  data;
		logic        ack_bit;
	} item_t;

	typedef struct packed {
		act_t       bus_action;
		logic [7:0] tx_byte;
		logic       need_data;
		logic       rx_valid;
		logic [7:0] rx_data;
		logic       rx_last;
		logic       done_res;
		st_t        status;
	} res_t;

endpackage

// File: design/iecs_fifo.sv
// Short first-in first-out queue of packed words.
module iecs_fifo import iecs_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);

	logic [W-1:0]     store_q [QDEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push_ok, pop_ok;

	assign full    = (cnt_q == CNT_W'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rdata   = store_q[rd_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			store_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ok) begin
				wr_q <= (wr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_q <= (rd_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: design/iecs_front.sv
// Front end: classifies requests, clamps the burst length and queues them.
module iecs_front import iecs_pkg::*; #(
	parameter int MAX_BURST = MAX_BURST_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  func,
	input  logic        op_read,
	input  logic [7:0]  device_byte,
	input  logic [15:0] mem_address,
	input  logic [8:0]  burst_length,
	input  logic [7:0]  write_byte,
	input  logic        ack_bit,
	input  logic [7:0]  rx_byte,
	output logic        item_valid,
	output item_t       item,
	input  logic        item_take
);

	item_t item_d;
	logic  item_empty;
	logic [8:0] len;

	always_comb begin
		len = burst_length;
		if (len == '0) begin
			len = 9'd1;
		end
		if (17'(len) > 17'(MAX_BURST)) begin
			len = 9'(MAX_BURST);
		end
	end

	always_comb begin
		item_d              = '0;
		item_d.op_read      = op_read;
		item_d.device_byte  = device_byte;
		item_d.mem_address  = mem_address;
		item_d.burst_length = len;
		item_d.ack_bit      = ack_bit;
		case (func)
			FUNC_BEGIN: begin
				item_d.kind = K_BEGIN;
			end
			FUNC_SUPPLY: begin
				item_d.kind = K_SUPPLY;
				item_d.data = write_byte;
			end
			FUNC_STEP: begin
				item_d.kind = K_STEP;
				item_d.data = rx_byte;
			end
			default: begin
				item_d.kind = K_NONE;
			end
		endcase
	end

	iecs_fifo #(.W($bits(item_t))) u_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (item_d),
		.full   (full),
		.pop    (item_take),
		.rdata  (item),
		.empty  (item_empty)
	);

	assign item_valid = !item_empty;

endmodule

// File: design/iecs_back.sv
// Back end: transaction state machine and result queue.
module iecs_back import iecs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	input  item_t item,
	output logic  item_take,
	output res_t  res,
	output logic  empty,
	input  logic  pop
);

	phase_t      phase_q, phase_d;
	logic        is_read_q, is_read_d;
	logic [7:0]  dev_q, dev_d;
	logic [15:0] addr_q, addr_d;
	logic [8:0]  left_q, left_d;
	st_t         fstat_q, fstat_d;
	res_t        res_d;
	logic        out_full;

	assign item_take = item_valid && !out_full;

	always_comb begin
		phase_d   = phase_q;
		is_read_d = is_read_q;
		dev_d     = dev_q;
		addr_d    = addr_q;
		left_d    = left_q;
		fstat_d   = fstat_q;
		res_d     = '0;
		case (item.kind)
			K_BEGIN: begin
				if (phase_q == PH_IDLE) begin
					is_read_d        = item.op_read;
					dev_d            = item.device_byte;
					addr_d           = item.mem_address;
					left_d           = item.burst_length;
					fstat_d          = ST_OK;
					res_d.bus_action = ACT_START;
					phase_d          = PH_START;
				end
			end
			K_SUPPLY: begin
				if (phase_q == PH_WDATA) begin
					res_d.bus_action = ACT_SEND;
					res_d.tx_byte    = item.data;
					if (left_q != '0) begin
						left_d = left_q - 9'd1;
					end
					phase_d = PH_SDATA;
				end
			end
			K_STEP: begin
				case (phase_q)
					PH_START: begin
						res_d.bus_action = ACT_SEND;
						res_d.tx_byte    = dev_q;
						phase_d          = PH_DEV;
					end
					PH_DEV: begin
						if (item.ack_bit) begin
							res_d.bus_action = ACT_STOP;
							fstat_d          = ST_DEV;
							phase_d          = PH_STOP;
						end else begin
							res_d.bus_action = ACT_SEND;
							res_d.tx_byte    = addr_q[15:8];
							phase_d          = PH_AHI;
						end
					end
					PH_AHI: begin
						if (item.ack_bit) begin
							res_d.bus_action = ACT_STOP;
							fstat_d          = ST_AHI;
							phase_d          = PH_STOP;
						end else begin
							res_d.bus_action = ACT_SEND;
							res_d.tx_byte    = addr_q[7:0];
							phase_d          = PH_ALO;
						end
					end
					PH_ALO: begin
						if (item.ack_bit) begin
							res_d.bus_action = ACT_STOP;
							fstat_d          = ST_ALO;
							phase_d          = PH_STOP;
						end else if (is_read_q) begin
							res_d.bus_action = ACT_RESTART;
							phase_d          = PH_RESTART;
						end else begin
							phase_d = PH_WDATA;
						end
					end
					PH_SDATA: begin
						if (left_q == '0) begin
							res_d.bus_action = ACT_STOP;
							fstat_d          = ST_OK;
							phase_d          = PH_STOP;
						end else begin
							phase_d = PH_WDATA;
						end
					end
					PH_RESTART: begin
						res_d.bus_action = ACT_SEND;
						res_d.tx_byte    = dev_q + 8'd1;
						phase_d          = PH_RSEL;
					end
					PH_RSEL: begin
						if (item.ack_bit) begin
							res_d.bus_action = ACT_STOP;
							fstat_d          = ST_RSEL;
							phase_d          = PH_STOP;
						end else begin
							res_d.bus_action = ACT_RECV;
							phase_d          = PH_RECV;
						end
					end
					PH_RECV: begin
						if (left_q != '0) begin
							left_d = left_q - 9'd1;
						end
						res_d.rx_valid   = 1'b1;
						res_d.rx_data    = item.data;
						res_d.rx_last    = (left_d == '0);
						res_d.bus_action = res_d.rx_last ? ACT_NACK : ACT_ACK;
						phase_d          = PH_ACKING;
					end
					PH_ACKING: begin
						if (left_q == '0) begin
							res_d.bus_action = ACT_STOP;
							fstat_d          = ST_OK;
							phase_d          = PH_STOP;
						end else begin
							res_d.bus_action = ACT_RECV;
							phase_d          = PH_RECV;
						end
					end
					PH_STOP: begin
						res_d.done_res = 1'b1;
						res_d.status   = fstat_q;
						phase_d        = PH_IDLE;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
		res_d.need_data = (phase_d == PH_WDATA);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			is_read_q <= 1'b0;
			dev_q     <= '0;
			addr_q    <= '0;
			left_q    <= '0;
			fstat_q   <= ST_OK;
		end else if (item_take) begin
			phase_q   <= phase_d;
			is_read_q <= is_read_d;
			dev_q     <= dev_d;
			addr_q    <= addr_d;
			left_q    <= left_d;
			fstat_q   <= fstat_d;
		end
	end

	iecs_fifo #(.W($bits(res_t))) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (item_take),
		.wdata  (res_d),
		.full   (out_full),
		.pop    (pop),
		.rdata  (res),
		.empty  (empty)
	);

endmodule

// File: design/i2c_eeprom_access_sequencer_core.sv
// Top level of the I2C EEPROM access sequencer.
// Results: a result is pushed into the result queue when its request is taken.
// Throughput: one request per cycle; the back-end state machine takes one
// queued request each cycle while its result queue has room.
// Reset: arst_n clears both queues and returns the sequencer to idle.
`include "assert_macros.svh"

module i2c_eeprom_access_sequencer_core import iecs_pkg::*; #(
	parameter int MAX_BURST = MAX_BURST_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  func,
	input  logic        op_read,
	input  logic [7:0]  device_byte,
	input  logic [15:0] mem_address,
	input  logic [8:0]  burst_length,
	input  logic [7:0]  write_byte,
	input  logic        ack_bit,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  bus_action,
	output logic [7:0]  tx_byte,
	output logic        need_data,
	output logic        rx_valid,
	output logic [7:0]  rx_data,
	output logic        rx_last,
	output logic        done_res,
	output logic [2:0]  status
);

	item_t item;
	logic  item_valid, item_take;
	res_t  res;

	iecs_front #(.MAX_BURST(MAX_BURST)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.func         (func),
		.op_read      (op_read),
		.device_byte  (device_byte),
		.mem_address  (mem_address),
		.burst_length (burst_length),
		.write_byte   (write_byte),
		.ack_bit      (ack_bit),
		.rx_byte      (rx_byte),
		.item_valid   (item_valid),
		.item         (item),
		.item_take    (item_take)
	);

	iecs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.res        (res),
		.empty      (empty),
		.pop        (pop)
	);

	assign bus_action = res.bus_action;
	assign tx_byte    = res.tx_byte;
	assign need_data  = res.need_data;
	assign rx_valid   = res.rx_valid;
	assign rx_data    = res.rx_data;
	assign rx_last    = res.rx_last;
	assign done_res   = res.done_res;
	assign status     = res.status;

	`CHK_IMPL(a_done_quiet, !empty && done_res, bus_action == ACT_NONE, "done with bus action")
	`CHK_IMPL(a_rx_ack, !empty && rx_valid, bus_action inside {ACT_ACK, ACT_NACK}, "rx without ack")
	`CHK_IMPL(a_last_nack, !empty && rx_last, rx_valid && bus_action == ACT_NACK, "last byte not nacked")
	`CHK_IMPL(a_status_done, !empty && status != ST_OK, done_res, "status outside done")

endmodule
